>>> hdl/macd_pkg.sv
// macd_pkg: widths, codes, command/status structs and saturation helper
// shared by every file of the macd_stream block; no dependencies
`default_nettype none
package macd_pkg;

  localparam int LEN_W          = 9;
  localparam int CFG_IDX_W      = 2;
  localparam int PRICE_W        = 32;
  localparam int ACC_W          = 64;
  localparam int OUT_W          = 48;
  localparam int STATUS_W       = 2;
  localparam int DIVR_W         = 10;
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS      = ACC_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  localparam logic [LEN_W-1:0] FAST_LEN_RST   = 9'd12;
  localparam logic [LEN_W-1:0] SLOW_LEN_RST   = 9'd26;
  localparam logic [LEN_W-1:0] SIGNAL_LEN_RST = 9'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_WARM  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_VALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

  localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] OUT_MIN = 64'shFFFF_8000_0000_0000;

  typedef enum logic [1:0] {STAGE_FAST, STAGE_SLOW, STAGE_SIGNAL} stage_t;
  typedef enum logic [1:0] {RES_BAD, RES_WARM, RES_VALID} res_kind_t;
  typedef enum logic [2:0] {ST_IDLE, ST_TRACK, ST_DIV, ST_MACD, ST_OUT} state_t;

  typedef struct packed {
    logic      load;
    logic      track;
    logic      wb;
    logic      macd;
    logic      out_load;
    stage_t    sel;
    res_kind_t kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad;
    logic need_div;
    logic div_done;
    logic early_macd;
    logic early_sig;
  } dp_status_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v;
    if (v > OUT_MAX) t = OUT_MAX;
    else if (v < OUT_MIN) t = OUT_MIN;
    return t[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/macd_if.sv
// macd_in_if / macd_out_if: valid/ready channels of the macd_stream block
// depends on macd_pkg for payload widths
`default_nettype none
interface macd_in_if import macd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;
  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

interface macd_out_if import macd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [OUT_W-1:0] macd_value;
  logic signed [OUT_W-1:0] signal_value;
  logic signed [OUT_W-1:0] histogram_value;
  modport source (output valid, output status, output macd_value, output signal_value,
                  output histogram_value, input ready);
  modport sink   (input valid, input status, input macd_value, input signal_value,
                  input histogram_value, output ready);
endinterface
`default_nettype wire

>>> hdl/macd_div.sv
// macd_div: iterative signed-by-unsigned divider, 4 quotient bits a cycle,
// truncating toward zero; depends on macd_pkg
`default_nettype none
module macd_div import macd_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [ACC_W-1:0] dividend,
  input  wire logic [DIVR_W-1:0]       divisor,
  output logic                         done,
  output logic signed [ACC_W-1:0]      quotient
);
  logic                 busy_r, prep_r, fin_r, done_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [ACC_W-1:0]     num_r;
  logic [DIVR_W:0]      rem_r;
  logic [DIVR_W-1:0]    den_r;
  logic [ACC_W-1:0]     q_r;
  logic [ACC_W-1:0]     num_nxt;
  logic [DIVR_W:0]      rem_nxt;

  // radix-16 step as four restoring bit steps
  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      rem_nxt = {rem_nxt[DIVR_W-1:0], num_nxt[ACC_W-1]};
      num_nxt = {num_nxt[ACC_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, den_r}) begin
        rem_nxt = rem_nxt - {1'b0, den_r};
        num_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      prep_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        prep_r <= 1'b1;
      end else if (prep_r) begin
        prep_r <= 1'b0;
        cnt_r  <= '0;
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) fin_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      neg_r <= dividend[ACC_W-1];
    end else if (prep_r) begin
      num_r <= neg_r ? (~num_r + 1'b1) : num_r;
      rem_r <= '0;
    end else if (fin_r) begin
      q_r <= neg_r ? (~num_r + 1'b1) : num_r;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

>>> hdl/macd_dp.sv
// macd_dp: configuration registers, averages, seed sums, divider and result register
// depends on macd_pkg and macd_div
`default_nettype none
module macd_dp import macd_pkg::*; #(
  parameter int MAX_PERIOD    = 256,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEN_W-1:0]     cfg_wdata,
  input  wire logic [PRICE_W-1:0]   price,
  input  wire ctrl_cmd_t            cmd,
  output dp_status_t                st,
  output logic [STATUS_W-1:0]       res_status,
  output logic signed [OUT_W-1:0]   res_macd,
  output logic signed [OUT_W-1:0]   res_signal,
  output logic signed [OUT_W-1:0]   res_hist
);
  localparam int CNT_W = $clog2(2 * MAX_PERIOD + 1);
  localparam int CMP_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(2 * MAX_PERIOD);
  localparam logic [CMP_W-1:0] MAX_LEN   = CMP_W'(MAX_PERIOD);

  logic [LEN_W-1:0] fast_len_r, slow_len_r, sig_len_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [ACC_W-1:0] fast_avg_r, slow_avg_r, sig_avg_r;
  logic [ACC_W-1:0] fast_sum_r, slow_sum_r, sig_sum_r;
  logic signed [ACC_W-1:0] x_r, macd_r;
  logic seed_r;

  logic [CMP_W-1:0] n_w, fl_w, sl_w, gl_w, pos_sig, pos_w, p_w;
  logic signed [ACC_W-1:0] xin, avg_sel, dividend;
  logic [ACC_W-1:0] sum_sel, sum_new;
  logic [DIVR_W-1:0] divisor;
  logic seed;
  logic div_done;
  logic signed [ACC_W-1:0] q;

  assign n_w     = CMP_W'(cnt_r);
  assign fl_w    = CMP_W'(fast_len_r);
  assign sl_w    = CMP_W'(slow_len_r);
  assign gl_w    = CMP_W'(sig_len_r);
  assign pos_sig = n_w - sl_w + 1'b1;

  always_comb begin
    unique case (cmd.sel)
      STAGE_SLOW: begin
        p_w = sl_w; pos_w = n_w; xin = x_r; sum_sel = slow_sum_r; avg_sel = slow_avg_r;
      end
      STAGE_SIGNAL: begin
        p_w = gl_w; pos_w = pos_sig; xin = macd_r; sum_sel = sig_sum_r; avg_sel = sig_avg_r;
      end
      default: begin
        p_w = fl_w; pos_w = n_w; xin = x_r; sum_sel = fast_sum_r; avg_sel = fast_avg_r;
      end
    endcase
    seed     = (pos_w <= p_w);
    sum_new  = sum_sel + xin;
    dividend = seed ? $signed(sum_new) : ((xin - avg_sel) <<< 1);
    divisor  = seed ? DIVR_W'(p_w) : DIVR_W'(p_w + 1'b1);
  end

  assign st.bad = (fast_len_r == '0) || (slow_len_r == '0) || (sig_len_r == '0) ||
                  (fl_w > MAX_LEN) || (sl_w > MAX_LEN) || (gl_w > MAX_LEN) ||
                  (fast_len_r >= slow_len_r);
  assign st.need_div   = !seed || (pos_w == p_w);
  assign st.div_done   = div_done;
  assign st.early_macd = (n_w < sl_w);
  assign st.early_sig  = (pos_sig < gl_w);

  macd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.track && st.need_div),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (q)
  );

  // stream state: cleared by reset and by any write to a length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_len_r <= FAST_LEN_RST;
      slow_len_r <= SLOW_LEN_RST;
      sig_len_r  <= SIGNAL_LEN_RST;
      cnt_r      <= '0;
      fast_avg_r <= '0; slow_avg_r <= '0; sig_avg_r <= '0;
      fast_sum_r <= '0; slow_sum_r <= '0; sig_sum_r <= '0;
    end else if (cfg_we && (cfg_index == CFG_FAST || cfg_index == CFG_SLOW ||
                            cfg_index == CFG_SIGNAL)) begin
      if (cfg_index == CFG_FAST)   fast_len_r <= cfg_wdata;
      if (cfg_index == CFG_SLOW)   slow_len_r <= cfg_wdata;
      if (cfg_index == CFG_SIGNAL) sig_len_r  <= cfg_wdata;
      cnt_r      <= '0;
      fast_avg_r <= '0; slow_avg_r <= '0; sig_avg_r <= '0;
      fast_sum_r <= '0; slow_sum_r <= '0; sig_sum_r <= '0;
    end else begin
      if (cmd.load && !st.bad && cnt_r < COUNT_CAP) cnt_r <= cnt_r + 1'b1;
      if (cmd.track && seed) begin
        unique case (cmd.sel)
          STAGE_SLOW:   slow_sum_r <= sum_new;
          STAGE_SIGNAL: sig_sum_r  <= sum_new;
          default:      fast_sum_r <= sum_new;
        endcase
      end
      if (cmd.wb) begin
        unique case (cmd.sel)
          STAGE_SLOW:   slow_avg_r <= seed_r ? q : slow_avg_r + q;
          STAGE_SIGNAL: sig_avg_r  <= seed_r ? q : sig_avg_r + q;
          default:      fast_avg_r <= seed_r ? q : fast_avg_r + q;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load)  x_r    <= $signed(ACC_W'(price) << FRACTION_BITS);
    if (cmd.track) seed_r <= seed;
    if (cmd.macd)  macd_r <= fast_avg_r - slow_avg_r;
    if (cmd.out_load) begin
      unique case (cmd.kind)
        RES_VALID: begin
          res_status <= STATUS_VALID;
          res_macd   <= sat_out(macd_r);
          res_signal <= sat_out(sig_avg_r);
          res_hist   <= sat_out(macd_r - sig_avg_r);
        end
        RES_WARM: begin
          res_status <= STATUS_WARM;
          res_macd <= '0; res_signal <= '0; res_hist <= '0;
        end
        default: begin
          res_status <= STATUS_BAD;
          res_macd <= '0; res_signal <= '0; res_hist <= '0;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hdl/macd_ctrl.sv
// macd_ctrl: sequencer for one price through fast, slow and signal stages
// depends on macd_pkg
`default_nettype none
module macd_ctrl import macd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t st,
  output ctrl_cmd_t       cmd
);
  state_t    state_r, state_nxt;
  stage_t    sel_r, sel_nxt;
  res_kind_t kind_r, kind_nxt;
  logic      out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= STAGE_FAST;
      kind_r      <= RES_WARM;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    logic adv;
    adv       = 1'b0;
    state_nxt = state_r;
    sel_nxt   = sel_r;
    kind_nxt  = kind_r;
    cmd       = '{load: 1'b0, track: 1'b0, wb: 1'b0, macd: 1'b0, out_load: 1'b0,
                  sel: sel_r, kind: kind_r};
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (st.bad) begin
            kind_nxt  = RES_BAD;
            state_nxt = ST_OUT;
          end else begin
            sel_nxt   = STAGE_FAST;
            state_nxt = ST_TRACK;
          end
        end
      end
      ST_TRACK: begin
        cmd.track = 1'b1;
        if (st.need_div) state_nxt = ST_DIV;
        else adv = 1'b1;
      end
      ST_DIV: begin
        if (st.div_done) begin
          cmd.wb = 1'b1;
          adv    = 1'b1;
        end
      end
      ST_MACD: begin
        if (st.early_macd) begin
          kind_nxt  = RES_WARM;
          state_nxt = ST_OUT;
        end else begin
          cmd.macd  = 1'b1;
          sel_nxt   = STAGE_SIGNAL;
          state_nxt = ST_TRACK;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (adv) begin
      unique case (sel_r)
        STAGE_FAST: begin
          sel_nxt   = STAGE_SLOW;
          state_nxt = ST_TRACK;
        end
        STAGE_SLOW: state_nxt = ST_MACD;
        default: begin
          kind_nxt  = st.early_sig ? RES_WARM : RES_VALID;
          state_nxt = ST_OUT;
        end
      endcase
    end
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.out_load;
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

>>> hdl/macd_stream.sv
// macd_stream: one price in, one result out (status, macd, signal, histogram)
// one price at a time; up to three divisions in macd_div, each started from the track state
// a new price is taken only after the last result is in the result register, which frees the input side
// synchronous active-low reset: periods 12/26/9, stream state cleared
// a register write also clears stream state; depends on macd_pkg, macd_if, macd_ctrl, macd_dp
`default_nettype none
module macd_stream import macd_pkg::*; #(
  parameter int MAX_PERIOD    = 256,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  macd_in_if.sink                   in_ch,
  macd_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEN_W-1:0]     cfg_wdata
);
  ctrl_cmd_t  cmd;
  dp_status_t st;

  // sequencer: idle, per-average track and divide, macd, result transfer
  macd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // averages, seed sums, shared divider and the result register
  macd_dp #(
    .MAX_PERIOD    (MAX_PERIOD),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .price      (in_ch.price),
    .cmd        (cmd),
    .st         (st),
    .res_status (out_ch.status),
    .res_macd   (out_ch.macd_value),
    .res_signal (out_ch.signal_value),
    .res_hist   (out_ch.histogram_value)
  );
endmodule
`default_nettype wire

>>> hdl/macd_checker.sv
// macd_checker: port-level assertions for macd_stream, bound to the top level
// depends on macd_pkg and macd_stream
`default_nettype none
module macd_checker import macd_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [STATUS_W-1:0]     status,
  input wire logic signed [OUT_W-1:0] macd,
  input wire logic signed [OUT_W-1:0] sig,
  input wire logic signed [OUT_W-1:0] hist
);
  // one price at a time: input closes right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("input open after transfer");

  // warm-up and bad-config results carry zero values
  a_zero_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STATUS_VALID |-> macd == '0 && sig == '0 && hist == '0)
    else $error("nonzero values without valid status");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(macd) &&
    $stable(sig) && $stable(hist)) else $error("stalled result changed");
endmodule

bind macd_stream macd_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .macd      (out_ch.macd_value),
  .sig       (out_ch.signal_value),
  .hist      (out_ch.histogram_value)
);
`default_nettype wire

>>> sim/tb_channels.sv
// tb-side note: channel interfaces come from hdl/macd_if.sv (macd_in_if, macd_out_if)
// this file holds the small helper package for random idle draws; depends on nothing
`default_nettype none
package tb_idle_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  function automatic int draw_gap();
    // about three items in seven get no gap at all
    if ($urandom_range(2, 0) == 0) return 0;
    return $urandom_range(6, 0);
  endfunction
endpackage
`default_nettype wire

>>> sim/tb.sv
// tb: self-checking bench for macd_stream, price stream in, macd/signal/histogram out
// predicts each result with its own fixed-point indicator model
// depends on macd_pkg, macd_if, tb_idle_pkg and the macd_stream rtl
`default_nettype none
module tb;
  import macd_pkg::*;
  import tb_idle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP   = 256;
  localparam int FRAC   = 16;
  localparam int CAP    = 2 * MAXP;
  localparam int LIMIT  = 900000;
  localparam int SETTLE = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [OUT_W-1:0] macd;
    logic signed [OUT_W-1:0] sig;
    logic signed [OUT_W-1:0] hist;
  } macd_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  macd_in_if  in_ch ();
  macd_out_if out_ch ();

  macd_stream #(.MAX_PERIOD(MAXP), .FRACTION_BITS(FRAC)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // indicator state mirrored from the block
  int unsigned len_fast, len_slow, len_sig;
  int unsigned n_seen;
  longint avg_fast, avg_slow, avg_sig;
  longint sum_fast, sum_slow, sum_sig;

  logic [PRICE_W-1:0] price_queue[$];
  macd_result_t       expected_results[$];
  int unsigned        mismatch_count = 0;
  longint unsigned    cycle_count = 0;
  bit                 hold_off = 1'b0;

  task automatic clear_indicator();
    n_seen = 0;
    avg_fast = 0; avg_slow = 0; avg_sig = 0;
    sum_fast = 0; sum_slow = 0; sum_sig = 0;
  endtask

  // seed with plain mean, then ema step with truncating divide
  task automatic ema_stage(input int unsigned pos, input int unsigned per, input longint x,
                           inout longint sum, inout longint avg);
    if (pos <= per) begin
      sum += x;
      if (pos == per) avg = sum / longint'(per);
    end else begin
      avg += ((x - avg) * 2) / longint'(per + 1);
    end
  endtask

  function automatic logic signed [OUT_W-1:0] clip48(input longint v);
    if (v > longint'(OUT_MAX)) return OUT_MAX[OUT_W-1:0];
    if (v < longint'(OUT_MIN)) return OUT_MIN[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

  task automatic predict_macd(input logic [PRICE_W-1:0] price);
    macd_result_t r;
    longint x, m;
    r = '0;
    if (len_fast == 0 || len_slow == 0 || len_sig == 0 || len_fast > MAXP ||
        len_slow > MAXP || len_sig > MAXP || len_fast >= len_slow) begin
      r.status = STATUS_BAD;
    end else begin
      r.status = STATUS_WARM;
      if (n_seen < CAP) n_seen++;
      x = longint'({32'd0, price}) <<< FRAC;
      ema_stage(n_seen, len_fast, x, sum_fast, avg_fast);
      ema_stage(n_seen, len_slow, x, sum_slow, avg_slow);
      if (n_seen >= len_slow) begin
        m = avg_fast - avg_slow;
        ema_stage(n_seen - len_slow + 1, len_sig, m, sum_sig, avg_sig);
        if (n_seen - len_slow + 1 >= len_sig) begin
          r.status = STATUS_VALID;
          r.macd = clip48(m);
          r.sig  = clip48(avg_sig);
          r.hist = clip48(m - avg_sig);
        end
      end
    end
    expected_results = {expected_results, r};
  endtask

  task automatic report(input string what, input logic [OUT_W-1:0] got,
                        input logic [OUT_W-1:0] want);
    mismatch_count++;
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
  endtask

  // driver: one price per transfer, random gap before each
  int unsigned in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.price <= '0;
    end else if (in_ch.valid && in_ch.ready) begin
      predict_macd(in_ch.price);
      in_gap = draw_gap();
      if (in_gap == 0 && price_queue.size() > 0) begin
        in_ch.price <= price_queue.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end else if (!in_ch.valid) begin
      if (in_gap > 0) in_gap--;
      else if (price_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.price <= price_queue.pop_front();
      end
    end
  end

  // monitor: random ready, compare each transfer with the oldest prediction
  int unsigned out_gap = 0;
  always @(posedge clk) begin
    macd_result_t want;
    cycle_count++;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", '0, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status)
            report("status", OUT_W'(out_ch.status), OUT_W'(want.status));
          if (out_ch.macd_value !== want.macd) report("macd", out_ch.macd_value, want.macd);
          if (out_ch.signal_value !== want.sig)
            report("signal", out_ch.signal_value, want.sig);
          if (out_ch.histogram_value !== want.hist)
            report("histogram", out_ch.histogram_value, want.hist);
        end
        out_gap = draw_gap();
      end else if (out_gap > 0) begin
        out_gap--;
      end
      out_ch.ready <= !hold_off && out_gap == 0;
    end
    if (cycle_count > LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // only the three listed registers exist; any other index changes nothing
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[LEN_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      CFG_FAST: begin
        len_fast = 32'(val[LEN_W-1:0]);
        clear_indicator();
      end
      CFG_SLOW: begin
        len_slow = 32'(val[LEN_W-1:0]);
        clear_indicator();
      end
      CFG_SIGNAL: begin
        len_sig = 32'(val[LEN_W-1:0]);
        clear_indicator();
      end
      default: ;
    endcase
  endtask

  // wait until the block is drained, then let it settle
  task automatic drain();
    while (price_queue.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_lengths(input int unsigned f, input int unsigned s, input int unsigned g);
    drain();
    write_reg(CFG_FAST, f);
    write_reg(CFG_SLOW, s);
    write_reg(CFG_SIGNAL, g);
  endtask

  task automatic add_price(input logic [PRICE_W-1:0] p);
    price_queue = {price_queue, p};
  endtask

  // mostly trending prices with noise, some extremes
  function automatic logic [PRICE_W-1:0] rand_price(input logic [PRICE_W-1:0] prev);
    case ($urandom_range(9, 0))
      0: return $urandom();
      1: return '1;
      2: return '0;
      default: return prev + $urandom_range(2000, 0) - 1000;
    endcase
  endfunction

  task automatic push_run(input int unsigned count);
    logic [PRICE_W-1:0] p;
    p = $urandom();
    repeat (count) begin
      p = rand_price(p);
      add_price(p);
    end
  endtask

  initial begin
    len_fast = 32'(FAST_LEN_RST);
    len_slow = 32'(SLOW_LEN_RST);
    len_sig  = 32'(SIGNAL_LEN_RST);
    clear_indicator();
    in_ch.valid = 1'b0;
    in_ch.price = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: shortest valid periods with extreme prices
    set_lengths(1, 2, 1);
    add_price('0);
    add_price('1);
    add_price('0);
    add_price('1);
    add_price(32'h5555_5555);
    add_price(32'hAAAA_AAAA);
    add_price(32'h0000_0001);
    add_price(32'h8000_0000);
    // bad configurations: zero period, fast not below slow, period beyond max
    set_lengths(0, 26, 9);
    add_price(32'd1234);
    set_lengths(26, 26, 9);
    add_price(32'd77);
    set_lengths(12, 300, 9);
    add_price('1);
    set_lengths(12, 26, 0);
    add_price(32'd5);
    set_lengths(511, 510, 511);
    add_price(32'd9);
    // defaults restored; a write to an unused index changes nothing
    set_lengths(FAST_LEN_RST, SLOW_LEN_RST, SIGNAL_LEN_RST);
    drain();
    write_reg(CFG_UNUSED, 9'h1FF);
    push_run(40);

    // backpressure: receiver holds off while prices keep coming
    drain();
    hold_off = 1'b1;
    push_run(20);
    repeat (600) @(posedge clk);
    hold_off = 1'b0;

    // random phases, including the largest periods
    set_lengths(12, 26, 9);   push_run(150);
    set_lengths(3, 5, 2);     push_run(100);
    set_lengths(255, 256, 256); push_run(60);
    set_lengths(1, 256, 1);   push_run(60);
    set_lengths($urandom_range(20, 1), $urandom_range(40, 21), $urandom_range(20, 1));
    push_run(120);

    drain();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
